// File: rtl/core/pqt_pkg.sv
// Package for the pending query table: operation and status codes, table constants.
// Used by pending_query_table_top and the port checker.
package pqt_pkg;

  typedef enum logic [1:0] {
    OP_REMEMBER = 2'd0,
    OP_CLAIM    = 2'd1,
    OP_SWEEP    = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_SKIPPED     = 3'd0,
    ST_INSERTED    = 3'd1,
    ST_REFRESHED   = 3'd2,
    ST_NOT_CLAIMED = 3'd3,
    ST_CLAIMED     = 3'd4,
    ST_SWEPT       = 3'd5
  } status_e;

  localparam logic [63:0] TimeoutReset = 64'd5000000000;

endpackage

// File: rtl/core/pqt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pqt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/core/pending_query_table_top.sv
// Pending query table top level: control sequencer around one slot RAM.
// Depends on pqt_pkg and pqt_ram.

// Outstanding query table with exact key match. It handles one item at a time.
// Remember and claim scan the slots for the key through the single slot RAM
// read port, one slot per cycle. A key found in a slot ends the scan; a miss
// scans every slot. An insert that pops a freed slot also passes through the
// pop state, which reads the link of the free-list head. The next input beat
// is taken at the earliest in the cycle after the result beat. Occupied bits
// live in flip-flops cleared at reset, so the slot RAM needs no clearing pass.
module pending_query_table_top #(
  parameter int CAPACITY    = 256,
  parameter int SWEEP_BATCH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [63:0] lookup_key_i,
  input  logic [63:0] question_tag_i,
  input  logic [63:0] now_ns_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [5:0]  removed_count_o,
  output logic        more_work_o
);

  localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int SlotW = 64 + 64 + 64 + 1 + CntW;
  localparam logic [CntW-1:0] CapC = CntW'(CAPACITY);
  localparam logic [CntW-1:0] BatchC =
      CntW'((SWEEP_BATCH < CAPACITY) ? SWEEP_BATCH : CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_ACT, S_POP, S_SWEEP, S_DONE
  } state_e;

  typedef struct packed {
    logic [63:0]     key;
    logic [63:0]     question;
    logic [63:0]     seen;
    logic            claimed;
    logic [CntW-1:0] link;
  } slot_t;

  state_e           state_q;
  logic [63:0]      timeout_q;
  logic [1:0]       op_q;
  logic [63:0]      key_q, q_q, now_q;
  logic [CAPACITY-1:0] occ_q;
  logic [CntW-1:0]  free_head_q, next_unused_q, remaining_q, count_q;
  logic [IdxW-1:0]  cursor_q;
  logic [CntW-1:0]  scan_q;      // address issued
  logic [CntW-1:0]  rd_idx_q;    // address of data on rdata
  logic             rd_vld_q;
  logic             found_q;
  logic [IdxW-1:0]  found_idx_q;
  slot_t            found_data_q;
  logic [5:0]       removed_q;
  logic [2:0]       status_q;
  logic             more_q;
  logic             out_valid_q;

  logic             we;
  logic [IdxW-1:0]  waddr, raddr;
  slot_t            wdata, rdata;

  pqt_ram #(.Width(SlotW), .Depth(CAPACITY)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  function automatic logic expired(input logic [63:0] seen, input logic [63:0] now,
                                   input logic [63:0] tmo);
    return (now < seen) || ((now - seen) >= tmo);
  endfunction

  logic            rd_hit;
  logic            sweep_free;
  logic [IdxW-1:0] rd_slot;

  assign rd_slot    = rd_idx_q[IdxW-1:0];
  assign rd_hit     = rd_vld_q && occ_q[rd_slot] && (rdata.key == key_q);
  assign sweep_free = rd_vld_q && occ_q[rd_slot] && expired(rdata.seen, now_q, timeout_q);

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign removed_count_o = removed_q;
  assign more_work_o = more_q;

  // RAM port control
  always_comb begin
    we    = 1'b0;
    waddr = found_idx_q;
    wdata = found_data_q;
    raddr = scan_q[IdxW-1:0];
    if (state_q == S_POP) raddr = free_head_q[IdxW-1:0];
    if (state_q == S_SWEEP && sweep_free) begin
      we            = 1'b1;
      waddr         = rd_slot;
      wdata         = rdata;
      wdata.claimed = 1'b0;
      wdata.link    = free_head_q;
    end else if (state_q == S_ACT) begin
      if (op_q == pqt_pkg::OP_REMEMBER && found_q) begin
        we = !found_data_q.claimed && (found_data_q.question == q_q);
        wdata.seen = now_q;
      end else if (op_q == pqt_pkg::OP_REMEMBER && !found_q) begin
        we = (free_head_q >= CapC) && (next_unused_q < CapC);
        waddr = next_unused_q[IdxW-1:0];
        wdata = '{key: key_q, question: q_q, seen: now_q, claimed: 1'b0,
                  link: CapC};
      end else if (op_q == pqt_pkg::OP_CLAIM) begin
        we = found_q && !found_data_q.claimed && (found_data_q.question == q_q)
             && !expired(found_data_q.seen, now_q, timeout_q);
        wdata.claimed = 1'b1;
      end
    end else if (state_q == S_POP && rd_vld_q) begin
      we    = 1'b1;
      waddr = found_idx_q;
      wdata = '{key: key_q, question: q_q, seen: now_q, claimed: 1'b0,
                link: CapC};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      timeout_q     <= pqt_pkg::TimeoutReset;
      op_q          <= '0;
      key_q         <= '0;
      q_q           <= '0;
      now_q         <= '0;
      occ_q         <= '0;
      free_head_q   <= CapC;
      next_unused_q <= '0;
      remaining_q   <= '0;
      cursor_q      <= '0;
      out_valid_q   <= 1'b0;
      rd_vld_q      <= 1'b0;
      rd_idx_q      <= '0;
      found_q       <= 1'b0;
      found_idx_q   <= '0;
      found_data_q  <= '0;
      scan_q        <= '0;
      count_q       <= '0;
      status_q      <= '0;
      removed_q     <= '0;
      more_q        <= 1'b0;
    end else begin
      if (cfg_we_i) timeout_q <= cfg_wdata_i;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      rd_idx_q <= scan_q;
      unique case (state_q)
        S_IDLE: begin
          rd_vld_q <= 1'b0;
          if (in_valid_i && in_ready_o) begin
            op_q      <= operation_i;
            key_q     <= lookup_key_i;
            q_q       <= question_tag_i;
            now_q     <= now_ns_i;
            found_q   <= 1'b0;
            removed_q <= '0;
            more_q    <= 1'b0;
            unique case (operation_i)
              pqt_pkg::OP_REMEMBER, pqt_pkg::OP_CLAIM: begin
                scan_q   <= '0;
                state_q  <= S_SCAN;
              end
              pqt_pkg::OP_SWEEP: begin
                scan_q   <= CntW'(cursor_q);
                count_q  <= ((remaining_q == '0) ? CapC : remaining_q) < BatchC ?
                            remaining_q : BatchC;
                if (remaining_q == '0) remaining_q <= CapC;
                state_q  <= S_SWEEP;
              end
              default: begin
                status_q <= pqt_pkg::ST_SKIPPED;
                state_q  <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          // rd_vld_q marks that rdata belongs to rd_idx_q
          if (rd_hit) begin
            found_q      <= 1'b1;
            found_idx_q  <= rd_slot;
            found_data_q <= rdata;
          end
          if (rd_hit || (rd_vld_q && rd_idx_q == CapC - 1'b1)) begin
            rd_vld_q <= 1'b0;
            state_q  <= S_ACT;
          end else begin
            rd_vld_q <= 1'b1;
            if (scan_q != CapC - 1'b1) scan_q <= scan_q + 1'b1;
          end
        end
        S_ACT: begin
          state_q <= S_DONE;
          if (op_q == pqt_pkg::OP_REMEMBER) begin
            if (found_q) begin
              status_q <= we ? pqt_pkg::ST_REFRESHED : pqt_pkg::ST_SKIPPED;
            end else if (free_head_q < CapC) begin
              found_idx_q <= free_head_q[IdxW-1:0];
              rd_vld_q    <= 1'b0;
              state_q     <= S_POP;
            end else if (next_unused_q < CapC) begin
              occ_q[next_unused_q[IdxW-1:0]] <= 1'b1;
              next_unused_q <= next_unused_q + 1'b1;
              status_q      <= pqt_pkg::ST_INSERTED;
            end else begin
              status_q <= pqt_pkg::ST_SKIPPED;
            end
          end else begin
            status_q <= we ? pqt_pkg::ST_CLAIMED : pqt_pkg::ST_NOT_CLAIMED;
          end
        end
        S_POP: begin
          rd_vld_q <= !rd_vld_q;
          if (rd_vld_q) begin
            free_head_q        <= rdata.link;
            occ_q[found_idx_q] <= 1'b1;
            status_q           <= pqt_pkg::ST_INSERTED;
            state_q            <= S_DONE;
          end
        end
        S_SWEEP: begin
          if (count_q != '0) begin
            count_q     <= count_q - 1'b1;
            remaining_q <= remaining_q - 1'b1;
            cursor_q    <= (CntW'(cursor_q) == CapC - 1'b1) ? '0 : cursor_q + 1'b1;
            scan_q      <= (CntW'(cursor_q) == CapC - 1'b1) ? '0 : CntW'(cursor_q) + 1'b1;
          end
          if (rd_vld_q && sweep_free) begin
            occ_q[rd_slot] <= 1'b0;
            free_head_q    <= CntW'(rd_slot);
            removed_q      <= removed_q + 1'b1;
          end
          // first cycle after issue has no data yet: rd_vld_q follows count
          if (count_q == '0) begin
            status_q <= pqt_pkg::ST_SWEPT;
            more_q   <= remaining_q != '0;
            rd_vld_q <= 1'b0;
            state_q  <= S_DONE;
          end else begin
            rd_vld_q <= 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/pqt_checker.sv
// Port properties for pending_query_table_top, bound to the top level.
// Depends on pqt_pkg.
module pqt_port_props (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] status_o,
  input logic [5:0] removed_count_o,
  input logic       more_work_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped while stalled");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("accepting with result pending");

  a_nonsweep_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != pqt_pkg::ST_SWEPT |-> removed_count_o == 6'd0 && !more_work_o)
    else $error("sweep fields on other op");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= pqt_pkg::ST_SWEPT)
    else $error("bad status");

endmodule

bind pending_query_table_top pqt_port_props u_pqt_port_props (.*);
